// ----- hdl/pressure_gradient_intensity_probe_assert.svh -----
// Assertion macros for the pressure gradient intensity probe.
// The macros expect clk and rst_n to be visible where they are used.
`ifndef PRESSURE_GRADIENT_INTENSITY_PROBE_ASSERT_SVH
`define PRESSURE_GRADIENT_INTENSITY_PROBE_ASSERT_SVH

// Checks that a condition holds at every clock edge outside reset.
`define PGIP_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("pgip assertion failed");

// Checks that a consequence holds whenever its condition holds.
`define PGIP_ASSERT_IMPLIES(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("pgip assertion failed");

`endif

// ----- hdl/pgip_pkg.sv -----
// Shared types, widths and helper functions of the pressure gradient intensity probe.
// Used by pgip_front, pgip_queue, pgip_back and the top level; depends on nothing.
package pgip_pkg;

    localparam int AXES          = 3;
    localparam int PRESSURE_W    = 24;
    localparam int GAIN_W        = 32;
    localparam int DIFF_W        = PRESSURE_W + 1;
    localparam int PROD_W        = DIFF_W + GAIN_W;
    localparam int ROUND_SHIFT   = 21;
    localparam int ROUND_BIAS    = 1 << (ROUND_SHIFT - 1);
    localparam int DELTA_W       = PROD_W - ROUND_SHIFT;
    localparam int ACC_W         = 48;
    localparam int SAT_W         = ACC_W + 2;
    localparam int SPLIT_W       = 24;
    localparam int HI_PROD_W     = (ACC_W - SPLIT_W) + PRESSURE_W;
    localparam int LO_PROD_W     = SPLIT_W + 1 + PRESSURE_W;
    localparam int INT_BIAS      = 1 << (SPLIT_W - 1);
    localparam int PART_W        = LO_PROD_W - SPLIT_W;
    localparam int INTENSITY_W   = 48;
    localparam int QUEUE_DEPTH   = 4;

    typedef logic signed [PRESSURE_W-1:0]  pressure_t;
    typedef logic signed [DELTA_W-1:0]     delta_t;
    typedef logic signed [ACC_W-1:0]       accum_t;
    typedef logic signed [INTENSITY_W-1:0] intensity_t;

    typedef struct packed {
        pressure_t center_pressure;
        pressure_t x_minus_pressure;
        pressure_t x_plus_pressure;
        pressure_t y_minus_pressure;
        pressure_t y_plus_pressure;
        pressure_t z_minus_pressure;
        pressure_t z_plus_pressure;
    } sample_t;

    typedef struct packed {
        intensity_t intensity_x;
        intensity_t intensity_y;
        intensity_t intensity_z;
        pressure_t  pressure_out;
    } result_t;

    typedef struct packed {
        logic [GAIN_W-1:0] velocity_gain;
    } cfg_t;

    typedef struct packed {
        delta_t [AXES-1:0] delta;
        pressure_t         pressure;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // Clamps a value with two guard bits to the signed 48-bit range.
    function automatic accum_t sat48(input logic signed [SAT_W-1:0] x);
        accum_t r;
        if ((x[SAT_W-1] == x[SAT_W-2]) && (x[SAT_W-2] == x[ACC_W-1]))
        begin
            r = x[ACC_W-1:0];
        end
        else if (x[SAT_W-1])
        begin
            r = {1'b1, {(ACC_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(ACC_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

// ----- hdl/pgip_stream_if.sv -----
// Valid/ready channel carrying one payload per transaction.
// The payload type is chosen at instantiation from pgip_pkg.
interface pgip_stream_if #(parameter type payload_t = logic);

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);

endinterface

// ----- hdl/pgip_front.sv -----
// Front stage: accepts samples, forms the axis differences and gain products.
// Pushes rounded velocity steps into the queue; uses pgip_pkg and pgip_stream_if.
module pgip_front (
    input  logic                          clk,
    input  logic                          rst_n,
    pgip_stream_if.sink                   samples,
    input  logic [pgip_pkg::GAIN_W-1:0]   velocity_gain,
    input  pgip_pkg::queue_status_t       q_status,
    output logic                          push,
    output pgip_pkg::entry_t              push_entry
);

    logic                 valid_reg;
    logic                 valid_next;
    logic                 accept;
    pgip_pkg::pressure_t  p_reg;
    pgip_pkg::pressure_t  minus_p [pgip_pkg::AXES];
    pgip_pkg::pressure_t  plus_p [pgip_pkg::AXES];

    assign samples.ready = !valid_reg || !q_status.full;
    assign accept        = samples.valid && samples.ready;
    assign push          = valid_reg && !q_status.full;

    always_comb
    begin
        minus_p[0] = samples.payload.x_minus_pressure;
        plus_p[0]  = samples.payload.x_plus_pressure;
        minus_p[1] = samples.payload.y_minus_pressure;
        plus_p[1]  = samples.payload.y_plus_pressure;
        minus_p[2] = samples.payload.z_minus_pressure;
        plus_p[2]  = samples.payload.z_plus_pressure;
    end

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p_reg <= samples.payload.center_pressure;
        end
    end

    assign push_entry.pressure = p_reg;

    for (genvar a = 0; a < pgip_pkg::AXES; a++)
    begin : g_lane
        logic signed [pgip_pkg::DIFF_W-1:0]   diff;
        logic signed [pgip_pkg::PROD_W:0]     wide;
        logic signed [pgip_pkg::PROD_W-1:0]   prod_reg;
        logic signed [pgip_pkg::PROD_W-1:0]   rounded;

        assign diff = pgip_pkg::DIFF_W'(plus_p[a]) - pgip_pkg::DIFF_W'(minus_p[a]);
        assign wide = diff * $signed({1'b0, velocity_gain});

        always_ff @(posedge clk)
        begin
            if (accept)
            begin
                prod_reg <= wide[pgip_pkg::PROD_W-1:0];
            end
        end

        assign rounded = prod_reg + pgip_pkg::PROD_W'(pgip_pkg::ROUND_BIAS);
        assign push_entry.delta[a] = rounded[pgip_pkg::PROD_W-1:pgip_pkg::ROUND_SHIFT];
    end

endmodule

// ----- hdl/pgip_queue.sv -----
// Short register queue between the front and back stages.
// Holds rounded velocity steps with their pressure; uses pgip_pkg.
module pgip_queue #(
    parameter int DEPTH = pgip_pkg::QUEUE_DEPTH
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  pgip_pkg::entry_t         push_entry,
    input  logic                     pop,
    output pgip_pkg::entry_t         head,
    output pgip_pkg::queue_status_t  status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pgip_pkg::entry_t  mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign head         = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ----- hdl/pgip_back.sv -----
// Back stage: updates the saturating velocity accumulators and forms the intensities.
// Pops the queue and drives the result channel; uses pgip_pkg and pgip_stream_if.
module pgip_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  pgip_pkg::entry_t         head,
    input  pgip_pkg::queue_status_t  q_status,
    output logic                     pop,
    pgip_stream_if.source            results
);

    logic                 advance;
    logic                 s1_valid_reg;
    logic                 s2_valid_reg;
    logic                 out_valid_reg;
    pgip_pkg::pressure_t  s1_p_reg;
    pgip_pkg::pressure_t  s2_p_reg;
    pgip_pkg::result_t    result_reg;
    pgip_pkg::result_t    result_next;
    pgip_pkg::intensity_t intensity [pgip_pkg::AXES];

    assign advance         = !out_valid_reg || results.ready;
    assign pop             = advance && !q_status.empty;
    assign results.valid   = out_valid_reg;
    assign results.payload = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= pop;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_p_reg   <= head.pressure;
            s2_p_reg   <= s1_p_reg;
            result_reg <= result_next;
        end
    end

    for (genvar a = 0; a < pgip_pkg::AXES; a++)
    begin : g_axis
        pgip_pkg::accum_t                          acc_reg;
        pgip_pkg::accum_t                          acc_next;
        logic signed [pgip_pkg::HI_PROD_W-1:0]     hi_prod_reg;
        logic signed [pgip_pkg::LO_PROD_W-1:0]     lo_prod_reg;
        logic signed [pgip_pkg::LO_PROD_W-1:0]     lo_rounded;
        logic signed [pgip_pkg::PART_W-1:0]        part;
        logic signed [pgip_pkg::SAT_W-1:0]         sum;

        assign acc_next = pgip_pkg::sat48(pgip_pkg::SAT_W'(acc_reg)
                                          - pgip_pkg::SAT_W'($signed(head.delta[a])));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                acc_reg <= '0;
            end
            else if (pop)
            begin
                acc_reg <= acc_next;
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                hi_prod_reg <= $signed(acc_reg[pgip_pkg::ACC_W-1:pgip_pkg::SPLIT_W]) * s1_p_reg;
                lo_prod_reg <= $signed({1'b0, acc_reg[pgip_pkg::SPLIT_W-1:0]}) * s1_p_reg;
            end
        end

        assign lo_rounded = lo_prod_reg + pgip_pkg::LO_PROD_W'(pgip_pkg::INT_BIAS);
        assign part       = lo_rounded[pgip_pkg::LO_PROD_W-1:pgip_pkg::SPLIT_W];
        assign sum        = pgip_pkg::SAT_W'(hi_prod_reg) + pgip_pkg::SAT_W'(part);
        assign intensity[a] = pgip_pkg::sat48(sum);
    end

    always_comb
    begin
        result_next.intensity_x  = intensity[0];
        result_next.intensity_y  = intensity[1];
        result_next.intensity_z  = intensity[2];
        result_next.pressure_out = s2_p_reg;
    end

endmodule

// ----- hdl/pressure_gradient_intensity_probe.sv -----
// Top level of the pressure gradient intensity probe.
// Instantiates pgip_front, pgip_queue and pgip_back; uses pgip_pkg and pgip_stream_if.
//
// The samples channel takes one simulation time step per transaction: the center
// pressure and the six neighbor pressures. The results channel returns one transaction
// per step with the three intensity components and the center pressure.
// The gain_cfg channel writes the velocity gain; it is always ready and should only be
// written while no step is in flight.
// A step passes the front registers, a queue entry, the s1 and s2 registers and the result
// register. One step can be accepted every cycle while the queue has room; the gain
// multipliers sit in the front stage and the velocity accumulators update in the back stage.
// Reset clears the three velocity accumulators, the gain and the queue.
// When the receiver stalls, the back pipeline holds, the queue fills up to its depth,
// and the samples channel then drops ready until the receiver takes a result.
module pressure_gradient_intensity_probe #(
    parameter int QUEUE_DEPTH = pgip_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    pgip_stream_if.sink     samples,
    pgip_stream_if.sink     gain_cfg,
    pgip_stream_if.source   results
);

    logic [pgip_pkg::GAIN_W-1:0]  gain_reg;
    logic                         push;
    logic                         pop;
    pgip_pkg::entry_t             push_entry;
    pgip_pkg::entry_t             head;
    pgip_pkg::queue_status_t      q_status;

    assign gain_cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= '0;
        end
        else if (gain_cfg.valid)
        begin
            gain_reg <= gain_cfg.payload.velocity_gain;
        end
    end

    pgip_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .samples       (samples),
        .velocity_gain (gain_reg),
        .q_status      (q_status),
        .push          (push),
        .push_entry    (push_entry)
    );

    pgip_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    pgip_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .results  (results)
    );

`include "pressure_gradient_intensity_probe_assert.svh"

    `PGIP_ASSERT_IMPLIES(a_push_has_room, push, !q_status.full)
    `PGIP_ASSERT_IMPLIES(a_pop_has_data, pop, !q_status.empty)
    `PGIP_ASSERT_ALWAYS(a_status_exclusive, !(q_status.full && q_status.empty))

endmodule
